[rtl/rigid_fit_error_search_assert.svh]
// Assertion macros for the rigid-fit error search checker.
// Used by rfes_checker.sv; needs clk and rst_n in scope where expanded.
`ifndef RIGID_FIT_ERROR_SEARCH_ASSERT_SVH
`define RIGID_FIT_ERROR_SEARCH_ASSERT_SVH

// Implication checked at every clock edge outside reset
`define RFES_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Condition checked in the cycle after the trigger
`define RFES_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/rfes_pkg.sv]
// Shared types, constants and trig helpers for the rigid-fit error search.
// No dependencies; imported by every module of the block.
`default_nettype none

package rfes_pkg;

  localparam int POINT_SLOTS = 4;
  localparam int ANGLE_STEPS = 360;
  localparam int SLOT_W      = 2;
  localparam int OP_W        = 2;
  localparam int COORD_W     = 24;
  localparam int ANG_W       = 9;
  localparam int COEF_W      = 16;
  localparam int ERR_W       = 24;
  localparam int POS_W       = 28;   // rotated coordinate
  localparam int DIFF_W      = 29;   // distance component, shared multiplier operand
  localparam int PROD_W      = 2 * DIFF_W;
  localparam int SQ_W        = 58;   // sum of squares
  localparam int RT_W        = SQ_W + 2;
  localparam int STEP_W      = 4;
  localparam int BIT_W       = 5;
  localparam int ROT_LAST    = 14;
  localparam int ROOT_TOP    = 28;   // sqrt scan starts at 4^28
  localparam int IN_TDATA_W  = 104;
  localparam int OUT_TDATA_W = 152;

  localparam logic [ERR_W-1:0] ERR_MAX = {ERR_W{1'b1}};

  typedef enum logic [OP_W-1:0] {
    OP_LOAD_SRC = 2'd0,
    OP_LOAD_TGT = 2'd1,
    OP_EVAL     = 2'd2,
    OP_NONE     = 2'd3
  } op_t;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic [ANG_W-1:0]          angle_t;
  typedef logic signed [COEF_W-1:0]  coef_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
  } point_t;

  // One classified item on its way from the front to the back
  typedef struct packed {
    op_t                op;
    logic [SLOT_W-1:0]  slot;
    point_t             pt;
    angle_t             pitch;
    angle_t             yaw;
    angle_t             roll;
    coef_t              sp;
    coef_t              cp;
    coef_t              sy;
    coef_t              cy;
    coef_t              sr;
    coef_t              cr;
  } item_t;

  // sin(d) * 32768 rounded, d = 0..90, top entry saturated
  localparam logic [14:0] SIN_Q15 [0:90] = '{
    15'd0,     15'd572,   15'd1144,  15'd1715,  15'd2286,  15'd2856,  15'd3425,
    15'd3993,  15'd4560,  15'd5126,  15'd5690,  15'd6252,  15'd6813,  15'd7371,
    15'd7927,  15'd8481,  15'd9032,  15'd9580,  15'd10126, 15'd10668, 15'd11207,
    15'd11743, 15'd12275, 15'd12803, 15'd13328, 15'd13848, 15'd14365, 15'd14876,
    15'd15384, 15'd15886, 15'd16384, 15'd16877, 15'd17364, 15'd17847, 15'd18324,
    15'd18795, 15'd19261, 15'd19720, 15'd20174, 15'd20622, 15'd21063, 15'd21498,
    15'd21926, 15'd22348, 15'd22763, 15'd23170, 15'd23571, 15'd23965, 15'd24351,
    15'd24730, 15'd25102, 15'd25466, 15'd25822, 15'd26170, 15'd26510, 15'd26842,
    15'd27166, 15'd27482, 15'd27789, 15'd28088, 15'd28378, 15'd28660, 15'd28932,
    15'd29197, 15'd29452, 15'd29698, 15'd29935, 15'd30163, 15'd30382, 15'd30592,
    15'd30792, 15'd30983, 15'd31164, 15'd31336, 15'd31499, 15'd31651, 15'd31795,
    15'd31928, 15'd32052, 15'd32166, 15'd32270, 15'd32365, 15'd32449, 15'd32524,
    15'd32588, 15'd32643, 15'd32688, 15'd32723, 15'd32748, 15'd32763, 15'd32767
  };

  // Fold a 9-bit angle into 0..359
  function automatic angle_t wrap_angle(input angle_t a);
    angle_t res;
    if (a >= ANG_W'(ANGLE_STEPS)) begin
      res = a - ANG_W'(ANGLE_STEPS);
    end else begin
      res = a;
    end
    return res;
  endfunction

  // Sine of a wrapped angle by quadrant symmetry
  function automatic coef_t sine(input angle_t a);
    logic [6:0] idx;
    logic       neg;
    coef_t      mag;
    if (a <= ANG_W'(90)) begin
      idx = 7'(a);
      neg = 1'b0;
    end else if (a <= ANG_W'(180)) begin
      idx = 7'(ANG_W'(180) - a);
      neg = 1'b0;
    end else if (a <= ANG_W'(270)) begin
      idx = 7'(a - ANG_W'(180));
      neg = 1'b1;
    end else begin
      idx = 7'(ANG_W'(ANGLE_STEPS) - a);
      neg = 1'b1;
    end
    mag = $signed({1'b0, SIN_Q15[idx]});
    return neg ? -mag : mag;
  endfunction

  // Cosine as the sine a quarter turn ahead
  function automatic coef_t cosine(input angle_t a);
    logic [ANG_W:0] b;
    b = {1'b0, a} + (ANG_W+1)'(90);
    if (b >= (ANG_W+1)'(ANGLE_STEPS)) begin
      b = b - (ANG_W+1)'(ANGLE_STEPS);
    end
    return sine(b[ANG_W-1:0]);
  endfunction

endpackage

`default_nettype wire

[rtl/rigid_fit_error_search.sv]
// Top level of the rigid-fit error search: front end, item queue, back end.
// Depends on rfes_pkg, rfes_front, rfes_fifo and rfes_back.
//
//  channel | direction | payload
//  in_     | slave     | tdata: slot, x, y, z, pitch, yaw, roll; tuser: op
//  out_    | master    | tdata: slot, error, improved, best fit; tlast: last
//
// A load is applied by the back end as it pops it. An evaluate runs each slot
// through one setup, 15 steps of the shared multiplier, 29 square-root bits
// (one per cycle) and one emit, for all four slots in turn. Reset is
// synchronous and clears queue, sequencer and best-fit record. The queue holds
// two items, so input is still taken while an evaluate runs until it fills;
// a stalled output holds the back end in its emit step.
`default_nettype none

module rigid_fit_error_search
  import rfes_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_tvalid,
  output logic                        in_tready,
  // slot[1:0], coord_x[25:2], coord_y[49:26], coord_z[73:50],
  // pitch[82:74], yaw[91:83], roll[100:92], zero fill
  input  wire logic [IN_TDATA_W-1:0]  in_tdata,
  // op[1:0]
  input  wire logic [OP_W-1:0]        in_tuser,
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  // out_slot[1:0], error[25:2], improved[26], best_error[50:27],
  // best_pitch[59:51], best_yaw[68:60], best_roll[77:69],
  // best_shift_x[101:78], best_shift_y[125:102], best_shift_z[149:126], zero fill
  output logic [OUT_TDATA_W-1:0]      out_tdata,
  output logic                        out_tlast
);

  logic  q_full;
  logic  q_push;
  logic  q_pop;
  logic  q_empty;
  item_t q_item;
  item_t q_head;

  rfes_front u_front (
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_item    (q_item)
  );

  rfes_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (q_item),
    .full      (q_full),
    .pop       (q_pop),
    .empty     (q_empty),
    .head      (q_head)
  );

  rfes_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_empty    (q_empty),
    .q_head     (q_head),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

`default_nettype wire

[rtl/rfes_front.sv]
// Front end: unpacks input items, drops unused op codes, wraps angles
// and looks up the six trig coefficients. Depends on rfes_pkg.
`default_nettype none

module rfes_front
  import rfes_pkg::*;
(
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic [IN_TDATA_W-1:0] in_tdata,
  input  wire logic [OP_W-1:0]       in_tuser,
  input  wire logic                  q_full,
  output logic                       q_push,
  output item_t                      q_item
);

  angle_t pitch_w;
  angle_t yaw_w;
  angle_t roll_w;

  // Accept whenever the queue has room; op code 3 is swallowed here
  assign in_tready = !q_full;
  assign q_push    = in_tvalid && !q_full && (op_t'(in_tuser) != OP_NONE);

  assign pitch_w = wrap_angle(in_tdata[82:74]);
  assign yaw_w   = wrap_angle(in_tdata[91:83]);
  assign roll_w  = wrap_angle(in_tdata[100:92]);

  // Build the queue entry
  always_comb begin
    q_item.op    = op_t'(in_tuser);
    q_item.slot  = in_tdata[1:0];
    q_item.pt.x  = in_tdata[25:2];
    q_item.pt.y  = in_tdata[49:26];
    q_item.pt.z  = in_tdata[73:50];
    q_item.pitch = pitch_w;
    q_item.yaw   = yaw_w;
    q_item.roll  = roll_w;
    q_item.sp    = sine(pitch_w);
    q_item.cp    = cosine(pitch_w);
    q_item.sy    = sine(yaw_w);
    q_item.cy    = cosine(yaw_w);
    q_item.sr    = sine(roll_w);
    q_item.cr    = cosine(roll_w);
  end

endmodule

`default_nettype wire

[rtl/rfes_fifo.sv]
// Two-entry queue of classified items between front and back.
// Depends on rfes_pkg for the entry type.
`default_nettype none

module rfes_fifo
  import rfes_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  push,
  input  wire item_t push_item,
  output logic       full,
  input  wire logic  pop,
  output logic       empty,
  output item_t      head
);

  item_t      mem_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] cnt_r;

  assign full  = (cnt_r == 2'd2);
  assign empty = (cnt_r == 2'd0);
  assign head  = mem_r[rd_ptr_r];

  // Store incoming entries
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      case ({push, pop})
        2'b10:   cnt_r <= cnt_r + 2'd1;
        2'b01:   cnt_r <= cnt_r - 2'd1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

`default_nettype wire

[rtl/rfes_back.sv]
// Back end: applies loads and runs each evaluate slot by slot through a
// shared multiplier and a bit-serial square root. Depends on rfes_pkg.
`default_nettype none

module rfes_back
  import rfes_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   q_empty,
  input  wire item_t                  q_head,
  output logic                        q_pop,
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  output logic [OUT_TDATA_W-1:0]      out_tdata,
  output logic                        out_tlast
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SETUP,
    S_ROT,
    S_SQRT,
    S_EMIT
  } state_t;

  state_t                   st_r;
  item_t                    item_r;
  logic [SLOT_W-1:0]        slot_r;
  logic [STEP_W-1:0]        step_r;
  logic [BIT_W-1:0]         bit_r;
  logic signed [POS_W-1:0]  x_r;
  logic signed [POS_W-1:0]  y_r;
  logic signed [POS_W-1:0]  z_r;
  logic signed [POS_W-1:0]  a_r;
  logic signed [POS_W-1:0]  b_r;
  logic [SQ_W-1:0]          sq_r;
  logic [RT_W-1:0]          rt_r;
  point_t                   src_r [POINT_SLOTS];
  point_t                   tgt_r [POINT_SLOTS];
  logic [ERR_W-1:0]         min_r [POINT_SLOTS];
  angle_t                   bp_r  [POINT_SLOTS];
  angle_t                   by_r  [POINT_SLOTS];
  angle_t                   br_r  [POINT_SLOTS];
  point_t                   bs_r  [POINT_SLOTS];
  logic                     out_valid_r;
  logic                     out_last_r;
  logic [OUT_TDATA_W-1:0]   out_data_r;

  logic signed [DIFF_W-1:0] dx;
  logic signed [DIFF_W-1:0] dy;
  logic signed [DIFF_W-1:0] dz;
  logic signed [DIFF_W-1:0] mul_a;
  logic signed [DIFF_W-1:0] mul_b;
  logic signed [PROD_W-1:0] prod;
  logic signed [POS_W-1:0]  qm;
  logic [RT_W-1:0]          sq_bit;
  logic [RT_W-1:0]          trial;
  logic [ERR_W-1:0]         err;
  logic                     imp;
  logic [ERR_W-1:0]         new_min;
  angle_t                   new_p;
  angle_t                   new_y;
  angle_t                   new_r;
  point_t                   new_s;
  logic                     out_free;
  logic                     emit_go;
  logic                     slot_ok;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;
  assign out_free   = !out_valid_r || out_tready;
  assign emit_go    = (st_r == S_EMIT) && out_free;
  assign q_pop      = (st_r == S_IDLE) && !q_empty;
  assign slot_ok    = int'(q_head.slot) < POINT_SLOTS;

  // Distance from the rotated point to this slot's target
  assign dx = DIFF_W'(tgt_r[slot_r].x) - DIFF_W'(x_r);
  assign dy = DIFF_W'(tgt_r[slot_r].y) - DIFF_W'(y_r);
  assign dz = DIFF_W'(tgt_r[slot_r].z) - DIFF_W'(z_r);

  // Pick the operands of the shared multiplier for this step
  always_comb begin
    case (step_r)
      4'd0:    begin mul_a = DIFF_W'(item_r.cr);  mul_b = DIFF_W'(x_r); end
      4'd1:    begin mul_a = -DIFF_W'(item_r.sr); mul_b = DIFF_W'(y_r); end
      4'd2:    begin mul_a = DIFF_W'(item_r.sr);  mul_b = DIFF_W'(x_r); end
      4'd3:    begin mul_a = DIFF_W'(item_r.cr);  mul_b = DIFF_W'(y_r); end
      4'd4:    begin mul_a = DIFF_W'(item_r.cy);  mul_b = DIFF_W'(x_r); end
      4'd5:    begin mul_a = DIFF_W'(item_r.sy);  mul_b = DIFF_W'(z_r); end
      4'd6:    begin mul_a = -DIFF_W'(item_r.sy); mul_b = DIFF_W'(x_r); end
      4'd7:    begin mul_a = DIFF_W'(item_r.cy);  mul_b = DIFF_W'(z_r); end
      4'd8:    begin mul_a = DIFF_W'(item_r.cp);  mul_b = DIFF_W'(y_r); end
      4'd9:    begin mul_a = -DIFF_W'(item_r.sp); mul_b = DIFF_W'(z_r); end
      4'd10:   begin mul_a = DIFF_W'(item_r.sp);  mul_b = DIFF_W'(y_r); end
      4'd11:   begin mul_a = DIFF_W'(item_r.cp);  mul_b = DIFF_W'(z_r); end
      4'd12:   begin mul_a = dx;                  mul_b = dx;           end
      4'd13:   begin mul_a = dy;                  mul_b = dy;           end
      4'd14:   begin mul_a = dz;                  mul_b = dz;           end
      default: begin mul_a = '0;                  mul_b = '0;           end
    endcase
  end

  // Product, and its Q1.15 scaling rounded toward minus infinity
  assign prod = mul_a * mul_b;
  assign qm   = prod[POS_W+14:15];

  // One root bit per cycle
  assign sq_bit = RT_W'(1) << {bit_r, 1'b0};
  assign trial  = rt_r + sq_bit;

  // Saturate the root and compare against the stored minimum
  always_comb begin
    if (rt_r > RT_W'(ERR_MAX)) begin
      err = ERR_MAX;
    end else begin
      err = rt_r[ERR_W-1:0];
    end
    imp     = err < min_r[slot_r];
    new_min = imp ? err         : min_r[slot_r];
    new_p   = imp ? item_r.pitch : bp_r[slot_r];
    new_y   = imp ? item_r.yaw   : by_r[slot_r];
    new_r   = imp ? item_r.roll  : br_r[slot_r];
    new_s   = imp ? item_r.pt    : bs_r[slot_r];
  end

  // Sequencer, point stores, best-fit record and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= S_IDLE;
      out_valid_r <= 1'b0;
      for (int k = 0; k < POINT_SLOTS; k++) begin
        min_r[k] <= ERR_MAX;
        bp_r[k]  <= '0;
        by_r[k]  <= '0;
        br_r[k]  <= '0;
        bs_r[k]  <= '0;
      end
    end else begin
      // Drop the taken item unless a new one replaces it this cycle
      if (out_tready && !emit_go) begin
        out_valid_r <= 1'b0;
      end
      case (st_r)
        S_IDLE: begin
          if (!q_empty) begin
            case (q_head.op)
              OP_LOAD_SRC: begin
                if (slot_ok) begin
                  src_r[q_head.slot] <= q_head.pt;
                end
              end
              OP_LOAD_TGT: begin
                if (slot_ok) begin
                  tgt_r[q_head.slot] <= q_head.pt;
                end
              end
              OP_EVAL: begin
                item_r <= q_head;
                slot_r <= '0;
                st_r   <= S_SETUP;
              end
              default: begin
              end
            endcase
          end
        end
        S_SETUP: begin
          // Shifted source point
          x_r    <= POS_W'(src_r[slot_r].x) + POS_W'(item_r.pt.x);
          y_r    <= POS_W'(src_r[slot_r].y) + POS_W'(item_r.pt.y);
          z_r    <= POS_W'(src_r[slot_r].z) + POS_W'(item_r.pt.z);
          step_r <= '0;
          st_r   <= S_ROT;
        end
        S_ROT: begin
          step_r <= step_r + STEP_W'(1);
          case (step_r) inside
            4'd0, 4'd4, 4'd8:  a_r <= qm;
            4'd1, 4'd5, 4'd9:  a_r <= a_r + qm;
            4'd2, 4'd6, 4'd10: b_r <= qm;
            4'd3: begin
              y_r <= b_r + qm;
              x_r <= a_r;
            end
            4'd7: begin
              z_r <= b_r + qm;
              x_r <= a_r;
            end
            4'd11: begin
              z_r <= b_r + qm;
              y_r <= a_r;
            end
            4'd12: sq_r <= SQ_W'($unsigned(prod));
            default: sq_r <= sq_r + SQ_W'($unsigned(prod));
          endcase
          if (step_r == STEP_W'(ROT_LAST)) begin
            rt_r  <= '0;
            bit_r <= BIT_W'(ROOT_TOP);
            st_r  <= S_SQRT;
          end
        end
        S_SQRT: begin
          if (RT_W'(sq_r) >= trial) begin
            sq_r <= sq_r - trial[SQ_W-1:0];
            rt_r <= (rt_r >> 1) + sq_bit;
          end else begin
            rt_r <= rt_r >> 1;
          end
          bit_r <= bit_r - BIT_W'(1);
          if (bit_r == '0) begin
            st_r <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            min_r[slot_r] <= new_min;
            bp_r[slot_r]  <= new_p;
            by_r[slot_r]  <= new_y;
            br_r[slot_r]  <= new_r;
            bs_r[slot_r]  <= new_s;
            out_valid_r   <= 1'b1;
            out_last_r    <= (slot_r == SLOT_W'(POINT_SLOTS - 1));
            out_data_r    <= {2'b00, new_s.z, new_s.y, new_s.x, new_r, new_y, new_p,
                              new_min, imp, err, slot_r};
            if (slot_r == SLOT_W'(POINT_SLOTS - 1)) begin
              st_r <= S_IDLE;
            end else begin
              slot_r <= slot_r + SLOT_W'(1);
              st_r   <= S_SETUP;
            end
          end
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

[rtl/rfes_checker.sv]
// Port-level checks on the result channel of the rigid-fit error search.
// Depends on rfes_pkg and rigid_fit_error_search_assert.svh; bound to the top.
`default_nettype none
`include "rigid_fit_error_search_assert.svh"

module rfes_checker
  import rfes_pkg::*;
(
  input wire logic                   clk,
  input wire logic                   rst_n,
  input wire logic                   out_tvalid,
  input wire logic                   out_tready,
  input wire logic [OUT_TDATA_W-1:0] out_tdata
);

  `RFES_ASSERT_NEXT(a_hold_valid, out_tvalid && !out_tready, out_tvalid, "result dropped while stalled")
  `RFES_ASSERT_NEXT(a_hold_data, out_tvalid && !out_tready, $stable(out_tdata), "result changed while stalled")
  `RFES_ASSERT_IMPL(a_imp_min, out_tvalid && out_tdata[26], out_tdata[50:27] == out_tdata[25:2], "improved result does not set the minimum")
  `RFES_ASSERT_IMPL(a_min_le, out_tvalid, out_tdata[50:27] <= out_tdata[25:2], "minimum above current error")

endmodule

bind rigid_fit_error_search rfes_checker u_rfes_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

`default_nettype wire

[sim/rigid_fit_error_search_test.sv]
// Testbench for rigid_fit_error_search: drives load and evaluate items and
// checks every slot result against an in-bench fixed-point predictor.
// Depends on rfes_pkg and the rigid_fit_error_search RTL.
`timescale 1ns / 100ps

module rigid_fit_error_search_test;
  import rfes_pkg::*;

  typedef struct packed {
    logic [1:0]  slot;
    logic [23:0] err;
    logic        improved;
    logic [23:0] best_err;
    logic [8:0]  bp, by, br;
    logic [23:0] bx, bsy, bz;
    logic        last;
  } fit_result_t;

  // Fixed-point predictor of the per-slot error and best-fit record
  class fit_scoreboard;
    longint src_pt[4][3];
    longint tgt_pt[4][3];
    logic [23:0] min_err[4];
    logic [8:0] best_ang[4][3];
    logic [23:0] best_shift[4][3];
    fit_result_t pending[$];
    int errors;

    function void clear();
      for (int k = 0; k < 4; k++) begin
        min_err[k] = '1;
        for (int j = 0; j < 3; j++) begin
          src_pt[k][j] = 0; tgt_pt[k][j] = 0;
          best_ang[k][j] = 0; best_shift[k][j] = 0;
        end
      end
      pending.delete();
      errors = 0;
    endfunction

    function longint table_sin(int a);
      if (a <= 90) return SIN_Q15[a];
      if (a <= 180) return SIN_Q15[180 - a];
      if (a <= 270) return -longint'(SIN_Q15[a - 180]);
      return -longint'(SIN_Q15[360 - a]);
    endfunction

    // Product truncated toward minus infinity
    function longint trunc_mul(longint k, longint v);
      return (k * v) >>> 15;
    endfunction

    function longint int_sqrt(longint unsigned n);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > n) b >>= 2;
      while (b != 0) begin
        if (n >= r + b) begin
          n -= r + b; r = (r >> 1) + b;
        end else begin
          r >>= 1;
        end
        b >>= 2;
      end
      return r;
    endfunction

    function void note_item(op_t op, logic [1:0] slot, logic [23:0] c[3], logic [8:0] a[3]);
      int ang[3];
      longint sh[3], s[3], co[3], x, y, z, t, dx, dy, dz;
      longint unsigned e;
      fit_result_t r;
      for (int j = 0; j < 3; j++) begin
        sh[j] = longint'($signed(c[j]));
        ang[j] = a[j] % 360;
        s[j] = table_sin(ang[j]);
        co[j] = table_sin((ang[j] + 90) % 360);
      end
      if (op == OP_LOAD_SRC || op == OP_LOAD_TGT) begin
        for (int j = 0; j < 3; j++)
          if (op == OP_LOAD_SRC) src_pt[slot][j] = sh[j];
          else tgt_pt[slot][j] = sh[j];
        return;
      end
      if (op != OP_EVAL) return;
      for (int k = 0; k < 4; k++) begin
        x = src_pt[k][0] + sh[0]; y = src_pt[k][1] + sh[1]; z = src_pt[k][2] + sh[2];
        // roll, yaw, then pitch
        t = trunc_mul(co[2], x) + trunc_mul(-s[2], y);
        y = trunc_mul(s[2], x) + trunc_mul(co[2], y); x = t;
        t = trunc_mul(co[1], x) + trunc_mul(s[1], z);
        z = trunc_mul(-s[1], x) + trunc_mul(co[1], z); x = t;
        t = trunc_mul(co[0], y) + trunc_mul(-s[0], z);
        z = trunc_mul(s[0], y) + trunc_mul(co[0], z); y = t;
        dx = tgt_pt[k][0] - x; dy = tgt_pt[k][1] - y; dz = tgt_pt[k][2] - z;
        e = int_sqrt(dx * dx + dy * dy + dz * dz);
        if (e > 64'hFFFFFF) e = 64'hFFFFFF;
        r.improved = e < min_err[k];
        if (r.improved) begin
          min_err[k] = e[23:0];
          for (int j = 0; j < 3; j++) begin
            best_ang[k][j] = 9'(ang[j]); best_shift[k][j] = c[j];
          end
        end
        r.slot = 2'(k); r.err = e[23:0]; r.best_err = min_err[k];
        r.bp = best_ang[k][0]; r.by = best_ang[k][1]; r.br = best_ang[k][2];
        r.bx = best_shift[k][0]; r.bsy = best_shift[k][1]; r.bz = best_shift[k][2];
        r.last = (k == 3);
        pending.insert(pending.size(), r);
      end
    endfunction

    function void check_result(fit_result_t got);
      fit_result_t want;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result slot %0d err %h", $time, got.slot, got.err);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (got !== want) begin
        $display("%0t: mismatch expected %p actual %p", $time, want, got);
        errors++;
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst_n = 0;
  logic in_tvalid = 0;
  logic in_tready;
  logic [IN_TDATA_W-1:0] in_tdata = '0;
  logic [OP_W-1:0] in_tuser = '0;
  logic out_tvalid;
  logic out_tready = 0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic out_tlast;

  fit_scoreboard board = new();
  bit long_hold = 0;
  bit burst_mode = 0;

  always #6 clk = ~clk;

  rigid_fit_error_search u_top (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready),
    .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tlast(out_tlast)
  );

  // Sample accepted results at the rising edge
  always @(posedge clk) begin
    fit_result_t got;
    if (rst_n && out_tvalid && out_tready) begin
      got.slot = out_tdata[1:0]; got.err = out_tdata[25:2];
      got.improved = out_tdata[26]; got.best_err = out_tdata[50:27];
      got.bp = out_tdata[59:51]; got.by = out_tdata[68:60]; got.br = out_tdata[77:69];
      got.bx = out_tdata[101:78]; got.bsy = out_tdata[125:102];
      got.bz = out_tdata[149:126]; got.last = out_tlast;
      board.check_result(got);
    end
  end

  // Receiver stall pattern, with a long hold-off on request
  initial begin
    int n;
    forever begin
      @(negedge clk);
      if (long_hold) begin
        out_tready <= 0;
        for (n = 0; n < 1500; n++) @(negedge clk);
        long_hold = 0;
      end else if (burst_mode) begin
        out_tready <= 1;
      end else begin
        out_tready <= ($urandom_range(0, 3) != 0);
      end
    end
  end

  // Offer one item and hold it until accepted; the caller drops valid
  task automatic send_item(op_t op, logic [1:0] slot, logic [23:0] x, logic [23:0] y,
                           logic [23:0] z, logic [8:0] p, logic [8:0] w, logic [8:0] r);
    logic [23:0] c[3];
    logic [8:0] a[3];
    c = '{x, y, z};
    a = '{p, w, r};
    in_tdata <= {3'b0, r, w, p, z, y, x, slot};
    in_tuser <= op;
    in_tvalid <= 1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    board.note_item(op, slot, c, a);
    @(negedge clk);
  endtask

  task automatic random_gap();
    int g;
    if ($urandom_range(0, 2) == 0) begin
      g = $urandom_range(1, 20);
      in_tvalid <= 0;
      repeat (g) @(negedge clk);
    end
  endtask

  task automatic wait_drained();
    in_tvalid <= 0;
    while (board.pending.size() != 0) @(negedge clk);
  endtask

  // Mostly small coordinates so errors stay meaningful, sometimes full range
  function automatic logic [23:0] rand_coord();
    case ($urandom_range(0, 3))
      0: return 24'($urandom());
      default: return 24'($signed($urandom_range(0, 8191)) - 4096);
    endcase
  endfunction

  task automatic load_all(bit extreme);
    for (int k = 0; k < 4; k++) begin
      if (extreme) begin
        send_item(OP_LOAD_SRC, 2'(k), 24'h7FFFFF, 24'h800000, 24'h7FFFFF, 9'h1FF, 0, 0);
        send_item(OP_LOAD_TGT, 2'(k), 24'h800000, 24'h7FFFFF, 24'h800000, 0, 9'h1FF, 0);
      end else begin
        send_item(OP_LOAD_SRC, 2'(k), rand_coord(), rand_coord(), rand_coord(),
                  9'($urandom()), 9'($urandom()), 9'($urandom()));
        send_item(OP_LOAD_TGT, 2'(k), rand_coord(), rand_coord(), rand_coord(),
                  9'($urandom()), 9'($urandom()), 9'($urandom()));
      end
    end
  endtask

  initial begin
    int sent;
    board.clear();
    repeat (6) @(negedge clk);
    rst_n <= 1;
    @(negedge clk);

    // Directed: extreme points, extreme shifts and angles, wrap, unused op
    load_all(1);
    send_item(OP_EVAL, 0, 24'h800000, 24'h800000, 24'h800000, 0, 0, 0);
    send_item(OP_EVAL, 3, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 359, 359, 359);
    send_item(OP_NONE, 2, 24'h123456, 0, 0, 90, 90, 90);
    load_all(0);
    send_item(OP_EVAL, 1, 0, 0, 0, 9'h1FF, 360, 270);
    send_item(OP_EVAL, 2, 0, 0, 0, 90, 180, 270);
    send_item(OP_EVAL, 0, 0, 0, 0, 180, 270, 90);
    send_item(OP_EVAL, 0, 0, 0, 0, 0, 0, 0);
    sent = 23;

    // Fill the block while the receiver holds off
    long_hold = 1;
    for (int i = 0; i < 6; i++)
      send_item(OP_EVAL, 0, rand_coord(), rand_coord(), rand_coord(),
                9'($urandom_range(0, 359)), 9'($urandom_range(0, 359)),
                9'($urandom_range(0, 359)));
    wait_drained();
    sent += 6;

    // Random: mostly evaluates, some reloads, a few unused ops
    while (sent < 330) begin
      int kind;
      if ($urandom_range(0, 40) == 0) wait_drained();
      burst_mode = ($urandom_range(0, 5) == 0);
      kind = $urandom_range(0, 9);
      if (kind < 6)
        send_item(OP_EVAL, 2'($urandom()), rand_coord(), rand_coord(), rand_coord(),
                  $urandom_range(0, 9) == 0 ? 9'($urandom()) : 9'($urandom_range(0, 359)),
                  $urandom_range(0, 9) == 0 ? 9'($urandom()) : 9'($urandom_range(0, 359)),
                  $urandom_range(0, 9) == 0 ? 9'($urandom()) : 9'($urandom_range(0, 359)));
      else if (kind < 9)
        send_item(kind == 6 ? OP_LOAD_SRC : OP_LOAD_TGT, 2'($urandom()), rand_coord(),
                  rand_coord(), rand_coord(), 9'($urandom()), 9'($urandom()),
                  9'($urandom()));
      else
        send_item(OP_NONE, 2'($urandom()), 24'($urandom()), 24'($urandom()),
                  24'($urandom()), 9'($urandom()), 9'($urandom()), 9'($urandom()));
      sent++;
      random_gap();
    end

    burst_mode = 0;
    wait_drained();
    repeat (400) @(negedge clk);
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #3000000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
